/* rtl/scwf_pkg.sv */
// Package with the types, character codes and defaults shared by the comment filter.
package scwf_pkg;

  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharNl    = 8'h0A;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [7:0] CharStar  = 8'h2A;

  localparam int unsigned ScwfQueueDepth = 2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_has_byte;
    logic       out_end;
  } out_t;

  // One classified word: up to two surviving bytes and the end-of-stream flag.
  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
    logic       last;
  } fq_t;

  typedef enum logic [2:0] {
    LC_NORMAL = 3'b001,
    LC_HELD   = 3'b010,
    LC_IN     = 3'b100
  } lc_e;

  typedef enum logic [3:0] {
    BC_NORMAL = 4'b0001,
    BC_HELD   = 4'b0010,
    BC_IN     = 4'b0100,
    BC_STAR   = 4'b1000
  } bc_e;

endpackage

/* rtl/scwf_front.sv */
// Front end: accepts input words, drops CR bytes, strips line and block comments.
module scwf_front (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  scwf_pkg::in_t in_data_i,
  output logic         push_o,
  output scwf_pkg::fq_t push_data_o,
  input  logic         full_i
);
  import scwf_pkg::*;

  typedef struct packed {
    bc_e        ph;
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
  } blk_res_t;

  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
  } lst_t;

  function automatic blk_res_t blk_feed(bc_e ph, logic [7:0] b);
    blk_res_t r;
    r.ph  = ph;
    r.cnt = 2'd0;
    r.b0  = b;
    r.b1  = b;
    unique case (ph)
      BC_NORMAL: begin
        if (b == CharSlash) begin
          r.ph = BC_HELD;
        end else begin
          r.cnt = 2'd1;
        end
      end
      BC_HELD: begin
        r.b0 = CharSlash;
        if (b == CharStar) begin
          r.ph = BC_STAR;
        end else if (b == CharSlash) begin
          r.cnt = 2'd1;
        end else begin
          r.cnt = 2'd2;
          r.ph  = BC_NORMAL;
        end
      end
      BC_IN: begin
        if (b == CharStar) begin
          r.ph = BC_STAR;
        end
      end
      BC_STAR: begin
        if (b == CharSlash) begin
          r.ph = BC_NORMAL;
        end else if (b != CharStar) begin
          r.ph = BC_IN;
        end
      end
      default: r.ph = BC_NORMAL;
    endcase
    return r;
  endfunction

  function automatic lst_t lst_push(lst_t l, logic [7:0] b);
    lst_t r;
    r = l;
    if (l.cnt == 2'd0) begin
      r.b0  = b;
      r.cnt = 2'd1;
    end else if (l.cnt == 2'd1) begin
      r.b1  = b;
      r.cnt = 2'd2;
    end
    return r;
  endfunction

  function automatic lst_t lst_add(lst_t l, blk_res_t r);
    lst_t o;
    o = l;
    if (r.cnt != 2'd0) begin
      o = lst_push(o, r.b0);
    end
    if (r.cnt == 2'd2) begin
      o = lst_push(o, r.b1);
    end
    return o;
  endfunction

  lc_e      lc_q, lc_d, lc_v;
  bc_e      bc_q, bc_d, bc_v;
  lst_t     lst;
  blk_res_t r0, r1, r2;
  logic     accept;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    lc_v = lc_q;
    bc_v = bc_q;
    lst  = '0;
    r0   = blk_feed(bc_v, in_data_i.in_byte);
    r1   = '0;
    r2   = '0;
    if (in_data_i.in_byte != CharCr) begin
      unique case (lc_q)
        LC_NORMAL: begin
          if (in_data_i.in_byte == CharSlash) begin
            lc_v = LC_HELD;
          end else begin
            bc_v = r0.ph;
            lst  = lst_add(lst, r0);
          end
        end
        LC_HELD: begin
          if (in_data_i.in_byte == CharSlash) begin
            lc_v = LC_IN;
          end else begin
            r1   = blk_feed(bc_v, CharSlash);
            lst  = lst_add(lst, r1);
            r2   = blk_feed(r1.ph, in_data_i.in_byte);
            bc_v = r2.ph;
            lst  = lst_add(lst, r2);
            lc_v = LC_NORMAL;
          end
        end
        LC_IN: begin
          if (in_data_i.in_byte == CharNl) begin
            lc_v = LC_NORMAL;
          end
        end
        default: lc_v = LC_NORMAL;
      endcase
    end
    if (in_data_i.in_last) begin
      if (lc_v == LC_HELD) begin
        r1   = blk_feed(bc_v, CharSlash);
        bc_v = r1.ph;
        lst  = lst_add(lst, r1);
      end
      if (bc_v == BC_HELD) begin
        lst = lst_push(lst, CharSlash);
      end
      lc_d = LC_NORMAL;
      bc_d = BC_NORMAL;
    end else begin
      lc_d = lc_v;
      bc_d = bc_v;
    end
  end

  assign push_o           = accept && ((lst.cnt != 2'd0) || in_data_i.in_last);
  assign push_data_o.cnt  = lst.cnt;
  assign push_data_o.b0   = lst.b0;
  assign push_data_o.b1   = lst.b1;
  assign push_data_o.last = in_data_i.in_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lc_q <= LC_NORMAL;
      bc_q <= BC_NORMAL;
    end else if (accept) begin
      lc_q <= lc_d;
      bc_q <= bc_d;
    end
  end

  a_last_resets_lc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.in_last |=> lc_q == LC_NORMAL && bc_q == BC_NORMAL)
    else $error("comment state not cleared after end of stream");

  a_last_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.in_last |-> push_o)
    else $error("end of stream word not queued");

endmodule

/* rtl/scwf_queue.sv */
// Small register queue between the comment stripper and the whitespace stage.
module scwf_queue #(
  parameter int unsigned Depth = scwf_pkg::ScwfQueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  scwf_pkg::fq_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output scwf_pkg::fq_t head_o
);
  import scwf_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  fq_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("queue count out of range");

endmodule

/* rtl/scwf_back.sv */
// Back end: newline, tab and space handling, end mark and output register.
module scwf_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  scwf_pkg::fq_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output scwf_pkg::out_t out_data_o
);
  import scwf_pkg::*;

  out_t       out_q, cur;
  logic       out_valid_q;
  logic       prev_q, p1, p2;
  logic       sel_q;
  logic [7:0] m0, m1;
  logic       keep0, keep1;
  out_t       res0, res1;
  logic [1:0] nres;
  logic       load, done;

  always_comb begin
    m0    = (head_i.b0 == CharNl) ? CharSpace : head_i.b0;
    m1    = (head_i.b1 == CharNl) ? CharSpace : head_i.b1;
    keep0 = (head_i.cnt != 2'd0) && (m0 != CharTab) && !((m0 == CharSpace) && prev_q);
    p1    = keep0 ? (m0 == CharSpace) : prev_q;
    keep1 = (head_i.cnt == 2'd2) && (m1 != CharTab) && !((m1 == CharSpace) && p1);
    p2    = keep1 ? (m1 == CharSpace) : p1;
    nres  = {1'b0, keep0} + {1'b0, keep1};
    res0  = '{out_byte: keep0 ? m0 : m1, out_has_byte: 1'b1, out_end: 1'b0};
    res1  = '{out_byte: m1, out_has_byte: 1'b1, out_end: 1'b0};
    if (head_i.last) begin
      if (nres == 2'd0) begin
        res0 = '{out_byte: 8'h00, out_has_byte: 1'b0, out_end: 1'b1};
        nres = 2'd1;
      end else if (nres == 2'd1) begin
        res0.out_end = 1'b1;
      end else begin
        res1.out_end = 1'b1;
      end
    end
    cur  = sel_q ? res1 : res0;
    done = ({1'b0, sel_q} == (nres - 2'd1));
  end

  assign load        = valid_i && (!out_valid_q || out_ready_i);
  assign pop_o       = load && ((nres == 2'd0) || done);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (load && (nres != 2'd0)) begin
      out_q <= cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sel_q       <= 1'b0;
      prev_q      <= 1'b0;
    end else begin
      if (load && (nres != 2'd0)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (load) begin
        if (pop_o) begin
          sel_q  <= 1'b0;
          prev_q <= head_i.last ? 1'b0 : p2;
        end else begin
          sel_q <= 1'b1;
        end
      end
    end
  end

  a_bare_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.out_has_byte |-> out_q.out_end && out_q.out_byte == 8'h00)
    else $error("bare result without end mark");

  a_no_tab_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.out_has_byte |->
      out_q.out_byte != CharTab && out_q.out_byte != CharNl)
    else $error("tab or newline reached the output");

  a_sel_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_q |-> valid_i)
    else $error("second result pending without a queued word");

endmodule

/* rtl/source_comment_whitespace_filter.sv */
// An accepted word is written into the queue; the output register then loads its first
// result. The front end takes one input word per cycle while the queue is not full, and
// still accepts while a result waits; a word with two results holds the whitespace stage
// and its output register until both are sent, which the queue (two entries by default)
// absorbs. Reset clears the comment state, queue and output register; no clearing pass.
module source_comment_whitespace_filter #(
  parameter int unsigned QueueDepth = scwf_pkg::ScwfQueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  scwf_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output scwf_pkg::out_t out_data_o
);
  import scwf_pkg::*;

  logic push, full, pop, q_valid;
  fq_t  push_data, head;

  scwf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  scwf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (head)
  );

  scwf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
